@@ rtl/abpm_pkg.sv @@
// shared types and constants of the achromatic bright pixel mask
package abpm_pkg;

  localparam int LEVEL_W    = 10;   // brightness b+g+r, 0..765
  localparam int CHAN_W     = 8;
  localparam int THR_W      = 17;   // achroma threshold, Q1.16
  localparam int RANK_W     = 7;
  localparam int FRAC_W     = 16;
  localparam int ACH_PROD_W = THR_W + LEVEL_W;

  // presence bitmap kept as rows of 16 levels
  localparam int ROW_BITS   = 16;
  localparam int BIT_IDX_W  = 4;
  localparam int ROW_IDX_W  = LEVEL_W - BIT_IDX_W;
  localparam int ROW_COUNT  = 48;

  // target index = rank * distinct / 100, via reciprocal
  localparam int PROD_W      = 17;
  localparam int QUOT_W      = 11;
  localparam int RECIP_SHIFT = 23;
  localparam logic [PROD_W-1:0] RECIP_K = 17'd83887;  // ceil(2^23 / 100)

  localparam logic [THR_W-1:0]  THR_RESET  = 17'd6554;
  localparam logic [RANK_W-1:0] RANK_RESET = 7'd90;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_RANK      = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_COLLECT  = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [RANK_W-1:0] rank;
    logic              rank_written;
  } cfg_t;

  typedef struct packed {
    opcode_t            op;
    logic [LEVEL_W-1:0] bright;
    logic               ach;
  } item_t;

  typedef struct packed {
    logic               mask_on;
    logic               level_found;
    logic [LEVEL_W-1:0] level_value;
  } result_t;

endpackage

@@ rtl/achromatic_bright_pixel_mask.sv @@
// top level of the achromatic bright pixel mask: config registers, front, queue, back
//
//   channel   signals                               handshake
//   pixel in  opcode, blue, green, red              start & !busy
//   result    mask_on, level_found, level_value     done, one cycle, no stall
//   config    cfg_we, cfg_index, cfg_data           cfg_we, write only
//
// the front takes a pixel every cycle while not busy and hands it to the queue once
// its sum, channel spread and threshold product are registered. back end: clear,
// cached classify and non-achromatic collect finish in idle; an achromatic collect
// adds a bitmap row read-modify-write. a classify after a frame or rank change walks
// levels: multiply, divide, clamp, each row read, each filled row loaded and scanned.
// busy rises when the queue and the front pipeline hold QUEUE_DEPTH items.
// reset clears control state and the row valid bits; the bitmap needs no clearing pass.
module achromatic_bright_pixel_mask #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [abpm_pkg::CHAN_W-1:0]   blue,
  input  logic [abpm_pkg::CHAN_W-1:0]   green,
  input  logic [abpm_pkg::CHAN_W-1:0]   red,
  output logic                          done,
  output logic                          mask_on,
  output logic                          level_found,
  output logic [abpm_pkg::LEVEL_W-1:0]  level_value,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [abpm_pkg::THR_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  abpm_pkg::cfg_t               cfg;
  abpm_pkg::item_t              push_item, head;
  abpm_pkg::result_t            res;
  logic [abpm_pkg::THR_W-1:0]   cfg_threshold;
  logic [abpm_pkg::RANK_W-1:0]  cfg_rank;
  logic                         push, pop, accept;
  logic [1:0]                   inflight;
  logic [CNT_W-1:0]             q_count;
  logic [CNT_W+1:0]             pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_threshold <= abpm_pkg::THR_RESET;
      cfg_rank      <= abpm_pkg::RANK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        abpm_pkg::CFG_THRESHOLD: cfg_threshold <= cfg_data;
        abpm_pkg::CFG_RANK:      cfg_rank      <= cfg_data[abpm_pkg::RANK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{threshold:    cfg_threshold,
                 rank:         cfg_rank,
                 rank_written: cfg_we && (cfg_index == abpm_pkg::CFG_RANK)};

  assign pending = (CNT_W+2)'(q_count) + (CNT_W+2)'(inflight);
  assign busy    = pending >= (CNT_W+2)'(QUEUE_DEPTH);
  assign accept  = start && !busy;

  abpm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .opcode   (opcode),
    .blue     (blue),
    .green    (green),
    .red      (red),
    .cfg      (cfg),
    .push     (push),
    .item     (push_item),
    .inflight (inflight)
  );

  abpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  abpm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_count != '0),
    .head    (head),
    .q_pop   (pop),
    .cfg     (cfg),
    .done    (done),
    .res     (res)
  );

  assign mask_on     = res.mask_on;
  assign level_found = res.level_found;
  assign level_value = res.level_value;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_count < CNT_W'(QUEUE_DEPTH)) || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_count != '0)
    else $error("queue pop while empty");

  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    (q_count == CNT_W'(QUEUE_DEPTH)) |-> busy)
    else $error("queue full but not busy");

  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    done && !level_found |-> (level_value == '0) && !mask_on)
    else $error("result without level carries a level or mask");

endmodule

@@ rtl/abpm_ram.sv @@
// generic single write port ram with registered read
module abpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/abpm_front.sv @@
// front end: takes pixels, sums channels and runs the achromatic test
module abpm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [1:0]                   opcode,
  input  logic [abpm_pkg::CHAN_W-1:0]  blue,
  input  logic [abpm_pkg::CHAN_W-1:0]  green,
  input  logic [abpm_pkg::CHAN_W-1:0]  red,
  input  abpm_pkg::cfg_t               cfg,
  output logic                         push,
  output abpm_pkg::item_t              item,
  output logic [1:0]                   inflight
);

  logic [abpm_pkg::CHAN_W-1:0]  hi, lo;
  logic [abpm_pkg::LEVEL_W-1:0] sum_in;

  logic                             v1, v2;
  abpm_pkg::opcode_t                op1, op2;
  logic [abpm_pkg::LEVEL_W-1:0]     sum1, sum2;
  logic [abpm_pkg::CHAN_W-1:0]      diff1, diff2;
  logic [abpm_pkg::ACH_PROD_W-1:0]  prod2;
  logic [abpm_pkg::ACH_PROD_W-1:0]  diff_scaled;

  always_comb begin
    hi = blue;
    lo = blue;
    if (green > hi) hi = green;
    if (red > hi)   hi = red;
    if (green < lo) lo = green;
    if (red < lo)   lo = red;
  end

  assign sum_in = abpm_pkg::LEVEL_W'(blue) + abpm_pkg::LEVEL_W'(green)
                + abpm_pkg::LEVEL_W'(red);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
    op1   <= abpm_pkg::opcode_t'(opcode);
    sum1  <= sum_in;
    diff1 <= hi - lo;
    op2   <= op1;
    sum2  <= sum1;
    diff2 <= diff1;
    prod2 <= abpm_pkg::ACH_PROD_W'(cfg.threshold) * abpm_pkg::ACH_PROD_W'(sum1);
  end

  // zero sum gives a zero product, so black never passes
  assign diff_scaled = abpm_pkg::ACH_PROD_W'({diff2, {abpm_pkg::FRAC_W{1'b0}}});

  assign item.op     = op2;
  assign item.bright = sum2;
  assign item.ach    = diff_scaled < prod2;

  assign push     = v2 && (op2 != abpm_pkg::OP_NONE);
  assign inflight = {1'b0, v1} + {1'b0, v2};

endmodule

@@ rtl/abpm_queue.sv @@
// short queue of classified items between front and back
module abpm_queue #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  abpm_pkg::item_t            push_item,
  input  logic                       pop,
  output abpm_pkg::item_t            head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  abpm_pkg::item_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign head = slots[rd_ptr];

endmodule

@@ rtl/abpm_back.sv @@
// back end: bitmap updates, level selection walk and result generation
module abpm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  abpm_pkg::item_t head,
  output logic            q_pop,
  input  abpm_pkg::cfg_t  cfg,
  output logic            done,
  output abpm_pkg::result_t res
);

  typedef enum logic [2:0] {
    S_IDLE, S_COLLECT, S_SEL_MUL, S_SEL_DIV, S_SEL_CLAMP, S_SEL_READ, S_SEL_LOAD, S_SEL_SCAN
  } state_t;

  localparam logic [abpm_pkg::ROW_IDX_W-1:0] LAST_ROW =
    abpm_pkg::ROW_IDX_W'(abpm_pkg::ROW_COUNT - 1);

  state_t                                state;
  abpm_pkg::item_t                       cur;
  logic [abpm_pkg::ROW_COUNT-1:0]        row_valid;
  logic [abpm_pkg::LEVEL_W-1:0]          distinct, cached_level, target, seen;
  logic                                  cache_valid;
  logic [abpm_pkg::PROD_W-1:0]           sel_prod;
  logic [abpm_pkg::QUOT_W-1:0]           quot;
  logic [abpm_pkg::ROW_IDX_W-1:0]        row;
  logic [abpm_pkg::BIT_IDX_W-1:0]        bitpos;
  logic [abpm_pkg::ROW_BITS-1:0]         shreg;

  logic                                  ram_re, ram_we;
  logic [abpm_pkg::ROW_IDX_W-1:0]        ram_raddr, cur_row;
  logic [abpm_pkg::ROW_BITS-1:0]         ram_rdata, ram_wdata, row_data, bit_mask;
  logic [2*abpm_pkg::PROD_W-1:0]         div_full;
  logic [abpm_pkg::QUOT_W-1:0]           div_q;
  logic [abpm_pkg::LEVEL_W-1:0]          last_idx, found_level;

  function automatic abpm_pkg::result_t make_result(abpm_pkg::item_t it,
                                                    logic [abpm_pkg::LEVEL_W-1:0] lvl,
                                                    logic found);
    abpm_pkg::result_t r;
    r.mask_on     = found && it.ach && (it.bright > lvl);
    r.level_found = found;
    r.level_value = lvl;
    return r;
  endfunction

  assign q_pop   = (state == S_IDLE) && q_valid;
  assign cur_row = cur.bright[abpm_pkg::LEVEL_W-1:abpm_pkg::BIT_IDX_W];

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = row;
    if (state == S_IDLE) begin
      ram_re    = q_valid && (head.op == abpm_pkg::OP_COLLECT) && head.ach;
      ram_raddr = head.bright[abpm_pkg::LEVEL_W-1:abpm_pkg::BIT_IDX_W];
    end else if (state == S_SEL_READ) begin
      ram_re    = row_valid[row];
    end
  end

  // rows never written since the last clear read as empty
  assign row_data  = row_valid[cur_row] ? ram_rdata : '0;
  assign bit_mask  = abpm_pkg::ROW_BITS'(1) << cur.bright[abpm_pkg::BIT_IDX_W-1:0];
  assign ram_we    = (state == S_COLLECT) && ((row_data & bit_mask) == '0);
  assign ram_wdata = row_data | bit_mask;

  // reciprocal is exact for rank up to 100; above that it can read one high,
  // but the quotient is past the last index either way and the clamp takes it
  assign div_full    = (2*abpm_pkg::PROD_W)'(sel_prod) * (2*abpm_pkg::PROD_W)'(abpm_pkg::RECIP_K);
  assign div_q       = div_full[abpm_pkg::RECIP_SHIFT +: abpm_pkg::QUOT_W];
  assign last_idx    = distinct - 1'b1;
  assign found_level = {row, bitpos};

  abpm_ram #(
    .WIDTH (abpm_pkg::ROW_BITS),
    .DEPTH (abpm_pkg::ROW_COUNT)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_row),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row_valid    <= '0;
      distinct     <= '0;
      cached_level <= '0;
      cache_valid  <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= head;
            case (head.op)
              abpm_pkg::OP_CLEAR: begin
                row_valid    <= '0;
                distinct     <= '0;
                cached_level <= '0;
                cache_valid  <= 1'b0;
              end
              abpm_pkg::OP_COLLECT: begin
                if (head.ach) state <= S_COLLECT;
              end
              abpm_pkg::OP_CLASSIFY: begin
                if (cache_valid) begin
                  done <= 1'b1;
                  res  <= make_result(head, cached_level, distinct != '0);
                end else begin
                  state <= S_SEL_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        S_COLLECT: begin
          if (ram_we) begin
            row_valid[cur_row] <= 1'b1;
            distinct           <= distinct + 1'b1;
            cache_valid        <= 1'b0;
          end
          state <= S_IDLE;
        end
        S_SEL_MUL: begin
          if (distinct == '0) begin
            cached_level <= '0;
            cache_valid  <= 1'b1;
            done         <= 1'b1;
            res          <= make_result(cur, '0, 1'b0);
            state        <= S_IDLE;
          end else begin
            sel_prod <= abpm_pkg::PROD_W'(cfg.rank) * abpm_pkg::PROD_W'(distinct);
            state    <= S_SEL_DIV;
          end
        end
        S_SEL_DIV: begin
          quot  <= div_q;
          state <= S_SEL_CLAMP;
        end
        S_SEL_CLAMP: begin
          target <= (quot > abpm_pkg::QUOT_W'(last_idx)) ? last_idx
                                                         : abpm_pkg::LEVEL_W'(quot);
          seen   <= '0;
          row    <= '0;
          state  <= S_SEL_READ;
        end
        S_SEL_READ: begin
          if (row_valid[row]) begin
            state <= S_SEL_LOAD;
          end else if (row == LAST_ROW) begin
            cached_level <= '0;
            cache_valid  <= 1'b1;
            done         <= 1'b1;
            res          <= make_result(cur, '0, 1'b1);
            state        <= S_IDLE;
          end else begin
            row <= row + 1'b1;
          end
        end
        S_SEL_LOAD: begin
          shreg  <= ram_rdata;
          bitpos <= '0;
          state  <= S_SEL_SCAN;
        end
        S_SEL_SCAN: begin
          if (shreg[0] && (seen == target)) begin
            cached_level <= found_level;
            cache_valid  <= 1'b1;
            done         <= 1'b1;
            res          <= make_result(cur, found_level, 1'b1);
            state        <= S_IDLE;
          end else begin
            if (shreg[0]) seen <= seen + 1'b1;
            shreg  <= shreg >> 1;
            bitpos <= bitpos + 1'b1;
            // no set bits left in this row
            if (shreg[abpm_pkg::ROW_BITS-1:1] == '0) begin
              if (row == LAST_ROW) begin
                cached_level <= '0;
                cache_valid  <= 1'b1;
                done         <= 1'b1;
                res          <= make_result(cur, '0, 1'b1);
                state        <= S_IDLE;
              end else begin
                row   <= row + 1'b1;
                state <= S_SEL_READ;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg.rank_written) cache_valid <= 1'b0;
    end
  end

endmodule

@@ dv/achromatic_bright_pixel_mask_test.sv @@
// self-checking testbench for the achromatic bright pixel mask
`timescale 1ns / 100ps

module achromatic_bright_pixel_mask_test;

  localparam int SETTLE_CYCLES = 1000;   // covers the longest level walk
  localparam int WATCHDOG      = 20000;
  localparam int ITEM_GOAL     = 1060;
  localparam int LEVELS        = 766;

  typedef enum logic [1:0] {
    BEAT_PIXEL,
    BEAT_WRITE,
    BEAT_DRAIN
  } beat_kind_t;

  typedef struct {
    beat_kind_t                  kind;
    abpm_pkg::opcode_t           op;
    logic [7:0]                  b;
    logic [7:0]                  g;
    logic [7:0]                  r;
    logic                        idx;
    logic [abpm_pkg::THR_W-1:0]  data;
    int unsigned                 idle_pct;
  } beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [1:0]                    opcode = abpm_pkg::OP_NONE;
  logic [abpm_pkg::CHAN_W-1:0]   blue = '0;
  logic [abpm_pkg::CHAN_W-1:0]   green = '0;
  logic [abpm_pkg::CHAN_W-1:0]   red = '0;
  logic                          done;
  logic                          mask_on;
  logic                          level_found;
  logic [abpm_pkg::LEVEL_W-1:0]  level_value;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = abpm_pkg::CFG_THRESHOLD;
  logic [abpm_pkg::THR_W-1:0]    cfg_data = '0;

  beat_t                         pending_beats[$];
  abpm_pkg::result_t             mask_results_due[$];

  // frame state as the block should hold it
  bit                            lvl_seen [LEVELS];
  int                            distinct_lvls = 0;
  logic [abpm_pkg::LEVEL_W-1:0]  level_cache = '0;
  bit                            level_cache_ok = 1'b0;
  logic [abpm_pkg::THR_W-1:0]    model_thr = abpm_pkg::THR_RESET;
  logic [abpm_pkg::RANK_W-1:0]   model_rank = abpm_pkg::RANK_RESET;

  int unsigned                   quiet_cycles = 0;
  int unsigned                   stall_cycles = 0;
  int unsigned                   n_counted = 0;
  int unsigned                   n_frames = 0;
  int unsigned                   n_accepted = 0;
  int unsigned                   n_checked = 0;
  int unsigned                   n_writes = 0;
  int unsigned                   mismatches = 0;
  logic                          launch;
  logic                          we_next;

  achromatic_bright_pixel_mask i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .done        (done),
    .mask_on     (mask_on),
    .level_found (level_found),
    .level_value (level_value),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit gray_enough(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    logic [7:0]      hi;
    logic [7:0]      lo;
    longint unsigned sum;
    sum = longint'(b) + longint'(g) + longint'(r);
    hi = b;
    lo = b;
    if (g > hi) hi = g;
    if (r > hi) hi = r;
    if (g < lo) lo = g;
    if (r < lo) lo = r;
    if (sum == 0) return 1'b0;
    return (longint'(hi - lo) << 16) < (longint'(model_thr) * sum);
  endfunction

  // advances the frame state by one accepted pixel beat
  function automatic void take_pixel(abpm_pkg::opcode_t op, logic [7:0] b, logic [7:0] g,
                                     logic [7:0] r);
    int                lum;
    int                target;
    int                seen;
    bit                ach;
    abpm_pkg::result_t res;
    lum = int'(b) + int'(g) + int'(r);
    case (op)
      abpm_pkg::OP_CLEAR: begin
        foreach (lvl_seen[i]) lvl_seen[i] = 1'b0;
        distinct_lvls = 0;
        level_cache = '0;
        level_cache_ok = 1'b0;
      end
      abpm_pkg::OP_COLLECT: begin
        if (gray_enough(b, g, r) && !lvl_seen[lum]) begin
          lvl_seen[lum] = 1'b1;
          distinct_lvls++;
          level_cache_ok = 1'b0;
        end
      end
      abpm_pkg::OP_CLASSIFY: begin
        if (!level_cache_ok) begin
          level_cache = '0;
          level_cache_ok = 1'b1;
          if (distinct_lvls != 0) begin
            target = (int'(model_rank) * distinct_lvls) / 100;
            if (target > distinct_lvls - 1) target = distinct_lvls - 1;
            seen = 0;
            for (int i = 0; i < LEVELS; i++) begin
              if (lvl_seen[i]) begin
                if (seen == target) begin
                  level_cache = abpm_pkg::LEVEL_W'(i);
                  break;
                end
                seen++;
              end
            end
          end
        end
        ach = gray_enough(b, g, r);
        res.mask_on = (distinct_lvls != 0) && ach && (lum > int'(level_cache));
        res.level_found = (distinct_lvls != 0);
        res.level_value = level_cache;
        mask_results_due.insert(mask_results_due.size(), res);
      end
      default: ;
    endcase
  endfunction

  // driver: one beat at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      launch = start && busy;
      we_next = 1'b0;
      if (start && !busy) begin
        take_pixel(abpm_pkg::opcode_t'(opcode), blue, green, red);
        n_accepted++;
      end
      if (!launch && pending_beats.size() != 0) begin
        case (pending_beats[0].kind)
          BEAT_PIXEL: begin
            if ($urandom_range(99) >= pending_beats[0].idle_pct) begin
              opcode <= pending_beats[0].op;
              blue <= pending_beats[0].b;
              green <= pending_beats[0].g;
              red <= pending_beats[0].r;
              launch = 1'b1;
              void'(pending_beats.pop_front());
            end
          end
          BEAT_WRITE: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              cfg_index <= pending_beats[0].idx;
              cfg_data <= pending_beats[0].data;
              we_next = 1'b1;
              if (pending_beats[0].idx == abpm_pkg::CFG_THRESHOLD) begin
                model_thr = pending_beats[0].data;
              end else begin
                model_rank = pending_beats[0].data[abpm_pkg::RANK_W-1:0];
                level_cache_ok = 1'b0;
              end
              n_writes++;
              void'(pending_beats.pop_front());
            end
          end
          default: begin
            // hold off until every due result is back
            if (quiet_cycles != 0) void'(pending_beats.pop_front());
          end
        endcase
      end
      start <= launch;
      cfg_we <= we_next;
      if (start || launch || done || mask_results_due.size() != 0) quiet_cycles <= 0;
      else if (quiet_cycles < SETTLE_CYCLES) quiet_cycles <= quiet_cycles + 1;
    end
  end

  // monitor: every done beat against the oldest due result
  always @(posedge clk) begin
    abpm_pkg::result_t due;
    if (!rst && done) begin
      if (mask_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result mask_on=%0b level_found=%0b level_value=%0d",
                   $time, mask_on, level_found, level_value);
      end else begin
        due = mask_results_due.pop_front();
        n_checked++;
        if (mask_on !== due.mask_on || level_found !== due.level_found ||
            level_value !== due.level_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: result %0d mismatch: expected mask_on=%0b level_found=%0b ",
                      "level_value=%0d, got mask_on=%0b level_found=%0b level_value=%0d"},
                     $time, n_checked, due.mask_on, due.level_found, due.level_value,
                     mask_on, level_found, level_value);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving anywhere
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_pixel(abpm_pkg::opcode_t op, logic [7:0] b, logic [7:0] g,
                            logic [7:0] r);
    beat_t bt;
    bt.kind = BEAT_PIXEL;
    bt.op = op;
    bt.b = b;
    bt.g = g;
    bt.r = r;
    bt.idx = abpm_pkg::CFG_THRESHOLD;
    bt.data = '0;
    // sender idle share per third of the run
    bt.idle_pct = (n_counted < ITEM_GOAL / 3) ? 33 : (n_counted < 2 * ITEM_GOAL / 3) ? 65 : 0;
    if (op != abpm_pkg::OP_NONE) n_counted++;
    if (op == abpm_pkg::OP_CLEAR) n_frames++;
    pending_beats.insert(pending_beats.size(), bt);
  endtask

  task automatic push_random(abpm_pkg::opcode_t op);
    push_pixel(op, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // channels close to one gray level, so most of them pass the achromatic test
  task automatic push_gray(abpm_pkg::opcode_t op);
    int base;
    int spread;
    int ch [3];
    base = int'($urandom_range(255));
    case ($urandom_range(3))
      0: spread = 0;
      1: spread = 2;
      2: spread = 8;
      default: spread = 40;
    endcase
    foreach (ch[i]) begin
      ch[i] = base + int'($urandom_range(2 * spread)) - spread;
      if (ch[i] < 0) ch[i] = 0;
      else if (ch[i] > 255) ch[i] = 255;
    end
    push_pixel(op, 8'(ch[0]), 8'(ch[1]), 8'(ch[2]));
  endtask

  task automatic push_write(logic idx, logic [abpm_pkg::THR_W-1:0] data);
    beat_t bt;
    bt.kind = BEAT_WRITE;
    bt.op = abpm_pkg::OP_NONE;
    bt.b = '0;
    bt.g = '0;
    bt.r = '0;
    bt.idx = idx;
    bt.data = data;
    bt.idle_pct = 0;
    pending_beats.insert(pending_beats.size(), bt);
  endtask

  task automatic push_drain();
    beat_t bt;
    bt.kind = BEAT_DRAIN;
    bt.op = abpm_pkg::OP_NONE;
    bt.b = '0;
    bt.g = '0;
    bt.r = '0;
    bt.idx = abpm_pkg::CFG_THRESHOLD;
    bt.data = '0;
    bt.idle_pct = 0;
    pending_beats.insert(pending_beats.size(), bt);
  endtask

  initial begin
    int nc;
    logic [abpm_pkg::THR_W-1:0] thr;
    logic [abpm_pkg::THR_W-1:0] rank;

    // empty frame, black pixels, ignored opcode
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd255, 8'd255, 8'd255);
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd0, 8'd0, 8'd0);
    push_pixel(abpm_pkg::OP_NONE, 8'd255, 8'd255, 8'd255);
    push_pixel(abpm_pkg::OP_COLLECT, 8'd0, 8'd0, 8'd0);
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd128, 8'd128, 8'd128);
    // a few levels, one chromatic pixel and a duplicate
    push_pixel(abpm_pkg::OP_COLLECT, 8'd255, 8'd255, 8'd255);
    push_pixel(abpm_pkg::OP_COLLECT, 8'd1, 8'd1, 8'd1);
    push_pixel(abpm_pkg::OP_COLLECT, 8'd255, 8'd0, 8'd0);
    push_pixel(abpm_pkg::OP_COLLECT, 8'd100, 8'd100, 8'd101);
    push_pixel(abpm_pkg::OP_COLLECT, 8'd255, 8'd255, 8'd255);
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd255, 8'd255, 8'd255);
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd0, 8'd0, 8'd0);
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd255, 8'd0, 8'd0);
    push_pixel(abpm_pkg::OP_NONE, 8'd0, 8'd0, 8'd0);
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd254, 8'd255, 8'd255);
    push_drain();
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd200, 8'd200, 8'd200);
    push_write(abpm_pkg::CFG_RANK, abpm_pkg::THR_W'(0));
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd2, 8'd2, 8'd2);
    // rank above 100 clamps to the top level
    push_write(abpm_pkg::CFG_RANK, abpm_pkg::THR_W'(127));
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd128, 8'd128, 8'd128);
    // zero threshold: nothing is achromatic
    push_write(abpm_pkg::CFG_THRESHOLD, abpm_pkg::THR_W'(0));
    push_pixel(abpm_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0);
    push_pixel(abpm_pkg::OP_COLLECT, 8'd50, 8'd50, 8'd50);
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd50, 8'd50, 8'd50);
    // full-scale threshold: every nonzero pixel is achromatic
    push_write(abpm_pkg::CFG_THRESHOLD, 17'h1FFFF);
    push_pixel(abpm_pkg::OP_COLLECT, 8'd255, 8'd0, 8'd0);
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd0, 8'd0, 8'd255);
    // 1.0 exactly: a pure primary sits right on the limit
    push_write(abpm_pkg::CFG_THRESHOLD, abpm_pkg::THR_W'(65536));
    push_pixel(abpm_pkg::OP_CLASSIFY, 8'd255, 8'd0, 8'd0);
    push_write(abpm_pkg::CFG_RANK, abpm_pkg::THR_W'(100));
    push_write(abpm_pkg::CFG_THRESHOLD, abpm_pkg::THR_RESET);

    while (n_counted < ITEM_GOAL) begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(7))
          0: thr = '0;
          1: thr = 17'h1FFFF;
          2: thr = abpm_pkg::THR_W'(65536);
          3: thr = abpm_pkg::THR_W'(1);
          4: thr = abpm_pkg::THR_RESET;
          default: thr = abpm_pkg::THR_W'($urandom_range(20000));
        endcase
        push_write(abpm_pkg::CFG_THRESHOLD, thr);
        if ($urandom_range(1) == 1) begin
          case ($urandom_range(5))
            0: rank = abpm_pkg::THR_W'(0);
            1: rank = abpm_pkg::THR_W'(100);
            2: rank = abpm_pkg::THR_W'(127);
            default: rank = abpm_pkg::THR_W'($urandom_range(100));
          endcase
          push_write(abpm_pkg::CFG_RANK, rank);
        end
      end
      if ($urandom_range(7) != 0) push_random(abpm_pkg::OP_CLEAR);
      nc = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 25);
      repeat (nc) begin
        case ($urandom_range(9))
          0: push_random(abpm_pkg::opcode_t'($urandom_range(3)));
          1: push_random(abpm_pkg::OP_COLLECT);
          default: push_gray(abpm_pkg::OP_COLLECT);
        endcase
      end
      if ($urandom_range(3) == 0) push_drain();
      nc = $urandom_range(1, 20);
      repeat (nc) begin
        case ($urandom_range(11))
          0: push_random(abpm_pkg::OP_NONE);
          1: push_gray(abpm_pkg::OP_COLLECT);
          2, 3, 4: push_random(abpm_pkg::OP_CLASSIFY);
          default: push_gray(abpm_pkg::OP_CLASSIFY);
        endcase
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_beats.size() != 0 || start || mask_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run covered %0d pixel beats in about %0d frames and %0d register writes",
             n_accepted, n_frames, n_writes);
    $display("%0d mask results checked, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0 && mask_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
